// ===== hw/rtl/kcs_pkg.sv =====
// Shared types and constants for the keyframe curve sampler.
// Used by the core, kcs_mul, kcs_div and the testbench; depends on nothing.
`timescale 1ns / 1ps

package kcs_pkg;

   // Keyframe store geometry.
   localparam int KEYS   = 64;
   localparam int KEY_AW = $clog2(KEYS);
   localparam int CNT_W  = $clog2(KEYS + 1);

   // Field widths.
   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int FACT_W    = FRAC_BITS + 1;
   localparam int MUL_W     = 34;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int ACC_W     = 72;
   localparam int TAN_W     = 48;
   localparam int BASIS_W   = 18;
   localparam int ENTRY_W   = 4 * WORD_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERP_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PLAY_SPEED  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PLAY_ENABLE = 2'd3;

   // Request kinds and interpolation modes.
   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;
   localparam logic [1:0] INTERP_LINEAR = 2'd0;
   localparam logic [1:0] INTERP_STEP   = 2'd1;
   localparam logic [1:0] INTERP_CUBIC  = 2'd2;

   // Arithmetic sequence steps of the shared multiplier.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_SPEED   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LIN_V0  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_LIN_V1  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_F2      = 4'd3;
   localparam logic [STEP_W-1:0] STEP_F3      = 4'd4;
   localparam logic [STEP_W-1:0] STEP_M0      = 4'd5;
   localparam logic [STEP_W-1:0] STEP_M1      = 4'd6;
   localparam logic [STEP_W-1:0] STEP_H00     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_H01     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_H10_LO  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_H10_HI  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_H11_LO  = 4'd11;
   localparam logic [STEP_W-1:0] STEP_H11_HI  = 4'd12;
   localparam logic [STEP_W-1:0] STEP_LAST    = 4'd13;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_LO_RD,
      ST_HI_RD,
      ST_HI_CAP,
      ST_DIV_INIT,
      ST_DIV_RUN,
      ST_CALC,
      ST_FINISH,
      ST_RESULT
   } state_type;

endpackage

// ===== hw/rtl/kcs_req_if.sv =====
// Request channel of the keyframe curve sampler: valid, ready and one request.
// Depends on nothing.
`timescale 1ns / 1ps

interface kcs_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [5:0]         key_index;
   logic [31:0]        key_time;
   logic signed [31:0] key_in_tangent;
   logic signed [31:0] key_value;
   logic signed [31:0] key_out_tangent;
   logic [31:0]        delta_time;

   modport source (output valid, mode, key_index, key_time, key_in_tangent, key_value,
                   key_out_tangent, delta_time, input ready);
   modport sink (input valid, mode, key_index, key_time, key_in_tangent, key_value,
                 key_out_tangent, delta_time, output ready);
endinterface

// ===== hw/rtl/kcs_rsp_if.sv =====
// Result channel of the keyframe curve sampler: valid, ready and one sample.
// Depends on nothing.
`timescale 1ns / 1ps

interface kcs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_value;
   logic               sample_complete;
   logic [5:0]         lower_key;

   modport source (output valid, sample_value, sample_complete, lower_key, input ready);
   modport sink (input valid, sample_value, sample_complete, lower_key, output ready);
endinterface

// ===== hw/rtl/keyframe_curve_sampler_core.sv =====
// Keyframe curve sampler: top level with the sequencer and keyframe store.
// Depends on kcs_pkg, kcs_req_if, kcs_rsp_if, kcs_ram, kcs_mul and kcs_div.
`timescale 1ns / 1ps

// This block samples one scalar animation curve and handles one request at a
// time. A load request writes one keyframe into the store and gives no result.
// An advance request scans the key times one by one (a read state and a compare
// state per key examined), reads the two bracketing keys, sets up the factor
// and, where the play time lies strictly inside a key interval, runs a
// sixteen-step serial division. The value is then formed on one shared
// multiplier: four steps for the step and linear modes, fourteen for the cubic
// Hermite mode, followed by a final state that rounds and saturates. The
// request channel is not ready while a request is in progress or its result is
// pending. With play_enable at zero an advance request is consumed with no
// result. The store is not cleared by reset: each key must be loaded before it
// is sampled.

module keyframe_curve_sampler_core (
   input  logic                              clock,
   input  logic                              reset,
   kcs_req_if.sink                           req_if,
   kcs_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [kcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kcs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = kcs_pkg::KEY_AW;
   localparam int CW = kcs_pkg::CNT_W;
   localparam int W  = kcs_pkg::WORD_W;

   kcs_pkg::state_type state_ff, state_in;

   // Configuration registers.
   logic [6:0]  key_count_ff, key_count_in;
   logic [1:0]  interp_mode_ff, interp_mode_in;
   logic [15:0] play_speed_ff, play_speed_in;
   logic        play_enable_ff, play_enable_in;

   // Playback state and per-request working registers.
   logic [W-1:0]        play_time_ff, play_time_in;
   logic [W-1:0]        delta_ff, delta_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic                done_ff, done_in;
   logic [W-1:0]        t_lo_ff, t_lo_in, t_hi_ff, t_hi_in;
   logic signed [W-1:0] v0_ff, v0_in, v1_ff, v1_in;
   logic signed [W-1:0] out_tan_ff, out_tan_in, in_tan_ff, in_tan_in;
   logic [W-1:0]        dur_ff, dur_in;
   logic [kcs_pkg::FACT_W-1:0] f_ff, f_in;
   logic [kcs_pkg::STEP_W-1:0] step_ff, step_in;
   logic signed [kcs_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [33:0]         f2_ff, f2_in;
   logic [48:0]         f3_ff, f3_in;
   logic signed [kcs_pkg::TAN_W-1:0] m0_ff, m0_in, m1_ff, m1_in;
   logic signed [kcs_pkg::BASIS_W-1:0] h00_ff, h00_in, h01_ff, h01_in;
   logic signed [kcs_pkg::BASIS_W-1:0] h10_ff, h10_in, h11_ff, h11_in;
   logic [W-1:0]        npt_ff, npt_in;

   // Result register.
   logic signed [W-1:0] sample_ff, sample_in;
   logic                complete_ff, complete_in;
   logic [5:0]          lower_ff, lower_in;

   // Store, multiplier and divider connections.
   logic                         ram_we;
   logic [AW-1:0]                ram_waddr, ram_raddr;
   logic [kcs_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;
   logic [W-1:0]                 rd_time;
   logic signed [W-1:0]          rd_in_tan, rd_value, rd_out_tan;
   logic signed [kcs_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [kcs_pkg::PROD_W-1:0] prod;
   logic                         div_start, div_done;
   logic [kcs_pkg::FRAC_BITS-1:0] div_q;

   logic           req_fire, advance_go;
   logic [CW-1:0]  n_eff;
   logic [W-1:0]   elapsed;
   logic           span_ok, el_ge_dur;

   assign req_fire   = req_if.valid && req_if.ready;
   assign advance_go = req_fire && (req_if.mode == kcs_pkg::MODE_ADVANCE) && play_enable_ff;

   // A key count of zero acts as one, and one above the store depth as the depth.
   always_comb begin
      if (key_count_ff == '0) begin
         n_eff = CW'(1);
      end else if (32'(key_count_ff) > kcs_pkg::KEYS) begin
         n_eff = CW'(kcs_pkg::KEYS);
      end else begin
         n_eff = CW'(key_count_ff);
      end
   end

   assign {rd_time, rd_in_tan, rd_value, rd_out_tan} = ram_rdata;

   assign span_ok   = t_hi_ff > t_lo_ff;
   assign elapsed   = (play_time_ff >= t_lo_ff) ? (play_time_ff - t_lo_ff) : '0;
   assign el_ge_dur = elapsed >= (t_hi_ff - t_lo_ff);
   assign div_start = (state_ff == kcs_pkg::ST_DIV_INIT) && span_ok && !el_ge_dur;

   kcs_ram #(
      .WIDTH (kcs_pkg::ENTRY_W),
      .DEPTH (kcs_pkg::KEYS)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   kcs_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   kcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (elapsed),
      .divisor  (t_hi_ff - t_lo_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kcs_pkg::ST_IDLE: begin
            if (advance_go) begin
               state_in = kcs_pkg::ST_SRCH_RD;
            end
         end
         kcs_pkg::ST_SRCH_RD:  state_in = kcs_pkg::ST_SRCH_CMP;
         kcs_pkg::ST_SRCH_CMP: begin
            if ((rd_time > play_time_ff) || ((idx_ff + 1'b1) == n_eff)) begin
               state_in = kcs_pkg::ST_LO_RD;
            end else begin
               state_in = kcs_pkg::ST_SRCH_RD;
            end
         end
         kcs_pkg::ST_LO_RD:  state_in = kcs_pkg::ST_HI_RD;
         kcs_pkg::ST_HI_RD:  state_in = kcs_pkg::ST_HI_CAP;
         kcs_pkg::ST_HI_CAP: state_in = kcs_pkg::ST_DIV_INIT;
         kcs_pkg::ST_DIV_INIT: begin
            state_in = div_start ? kcs_pkg::ST_DIV_RUN : kcs_pkg::ST_CALC;
         end
         kcs_pkg::ST_DIV_RUN: begin
            if (div_done) begin
               state_in = kcs_pkg::ST_CALC;
            end
         end
         kcs_pkg::ST_CALC: begin
            if ((step_ff == kcs_pkg::STEP_LAST) ||
                ((step_ff == kcs_pkg::STEP_F2) && (interp_mode_ff != kcs_pkg::INTERP_CUBIC))) begin
               state_in = kcs_pkg::ST_FINISH;
            end
         end
         kcs_pkg::ST_FINISH: state_in = kcs_pkg::ST_RESULT;
         kcs_pkg::ST_RESULT: begin
            if (rsp_if.ready) begin
               state_in = kcs_pkg::ST_IDLE;
            end
         end
         default: state_in = kcs_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake, store read address and multiplier operands.
   always_comb begin
      req_if.ready = (state_ff == kcs_pkg::ST_IDLE);
      rsp_if.valid = (state_ff == kcs_pkg::ST_RESULT);
      ram_we    = req_fire && (req_if.mode == kcs_pkg::MODE_LOAD) &&
                  (32'(req_if.key_index) < kcs_pkg::KEYS);
      ram_waddr = AW'(req_if.key_index);
      ram_wdata = {req_if.key_time, req_if.key_in_tangent, req_if.key_value,
                   req_if.key_out_tangent};
      case (state_ff)
         kcs_pkg::ST_LO_RD: ram_raddr = lo_ff;
         kcs_pkg::ST_HI_RD: ram_raddr = hi_ff;
         default:           ram_raddr = idx_ff[AW-1:0];
      endcase
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         kcs_pkg::STEP_SPEED: begin
            mul_a = kcs_pkg::MUL_W'({1'b0, delta_ff});
            mul_b = kcs_pkg::MUL_W'({1'b0, play_speed_ff});
         end
         kcs_pkg::STEP_LIN_V0: begin
            mul_a = kcs_pkg::MUL_W'(v0_ff);
            mul_b = kcs_pkg::MUL_W'({1'b0, 17'd65536 - f_ff});
         end
         kcs_pkg::STEP_LIN_V1: begin
            mul_a = kcs_pkg::MUL_W'(v1_ff);
            mul_b = kcs_pkg::MUL_W'({1'b0, f_ff});
         end
         kcs_pkg::STEP_F2: begin
            mul_a = kcs_pkg::MUL_W'({1'b0, f_ff});
            mul_b = kcs_pkg::MUL_W'({1'b0, f_ff});
         end
         kcs_pkg::STEP_F3: begin
            // The square is still on the product register in this step.
            mul_a = prod[kcs_pkg::MUL_W-1:0];
            mul_b = kcs_pkg::MUL_W'({1'b0, f_ff});
         end
         kcs_pkg::STEP_M0: begin
            mul_a = kcs_pkg::MUL_W'(out_tan_ff);
            mul_b = kcs_pkg::MUL_W'({1'b0, dur_ff});
         end
         kcs_pkg::STEP_M1: begin
            mul_a = kcs_pkg::MUL_W'(in_tan_ff);
            mul_b = kcs_pkg::MUL_W'({1'b0, dur_ff});
         end
         kcs_pkg::STEP_H00: begin
            mul_a = kcs_pkg::MUL_W'(h00_ff);
            mul_b = kcs_pkg::MUL_W'(v0_ff);
         end
         kcs_pkg::STEP_H01: begin
            mul_a = kcs_pkg::MUL_W'(h01_ff);
            mul_b = kcs_pkg::MUL_W'(v1_ff);
         end
         kcs_pkg::STEP_H10_LO: begin
            mul_a = kcs_pkg::MUL_W'(h10_ff);
            mul_b = kcs_pkg::MUL_W'({1'b0, m0_ff[23:0]});
         end
         kcs_pkg::STEP_H10_HI: begin
            mul_a = kcs_pkg::MUL_W'(h10_ff);
            mul_b = kcs_pkg::MUL_W'($signed(m0_ff[47:24]));
         end
         kcs_pkg::STEP_H11_LO: begin
            mul_a = kcs_pkg::MUL_W'(h11_ff);
            mul_b = kcs_pkg::MUL_W'({1'b0, m1_ff[23:0]});
         end
         kcs_pkg::STEP_H11_HI: begin
            mul_a = kcs_pkg::MUL_W'(h11_ff);
            mul_b = kcs_pkg::MUL_W'($signed(m1_ff[47:24]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      rsp_if.sample_value    = sample_ff;
      rsp_if.sample_complete = complete_ff;
      rsp_if.lower_key       = lower_ff;
   end

   // Datapath next values.
   always_comb begin
      logic signed [63:0] bf, bf2, bf3, x00, x10, x01, x11;
      logic [40:0]        pt_sum;
      logic signed [55:0] rnd;
      logic signed [kcs_pkg::PROD_W-1:0] tan_rnd;

      key_count_in   = key_count_ff;
      interp_mode_in = interp_mode_ff;
      play_speed_in  = play_speed_ff;
      play_enable_in = play_enable_ff;
      play_time_in   = play_time_ff;
      delta_in    = delta_ff;
      idx_in      = idx_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      done_in     = done_ff;
      t_lo_in     = t_lo_ff;
      t_hi_in     = t_hi_ff;
      v0_in       = v0_ff;
      v1_in       = v1_ff;
      out_tan_in  = out_tan_ff;
      in_tan_in   = in_tan_ff;
      dur_in      = dur_ff;
      f_in        = f_ff;
      step_in     = step_ff;
      acc_in      = acc_ff;
      f2_in       = f2_ff;
      f3_in       = f3_ff;
      m0_in       = m0_ff;
      m1_in       = m1_ff;
      h00_in      = h00_ff;
      h01_in      = h01_ff;
      h10_in      = h10_ff;
      h11_in      = h11_ff;
      npt_in      = npt_ff;
      sample_in   = sample_ff;
      complete_in = complete_ff;
      lower_in    = lower_ff;

      bf  = 64'(f_ff);
      bf2 = 64'(f2_ff);
      bf3 = 64'(f3_ff);
      x00 = 2 * bf3 - 3 * (bf2 <<< 16) + (64'sd1 <<< 48) + (64'sd1 <<< 31);
      x10 = bf3 - 2 * (bf2 <<< 16) + (bf <<< 32) + (64'sd1 <<< 31);
      x01 = 3 * (bf2 <<< 16) - 2 * bf3 + (64'sd1 <<< 31);
      x11 = bf3 - (bf2 <<< 16) + (64'sd1 <<< 31);
      tan_rnd = (prod + 68'sd32768) >>> 16;
      pt_sum  = {9'd0, play_time_ff} + {1'b0, prod[47:8]};
      rnd     = 56'((acc_ff + 72'sd32768) >>> 16);

      // Register writes must only be made while the block is idle; the block does not enforce this.
      if (csr_we) begin
         case (csr_index)
            kcs_pkg::REG_KEY_COUNT:   key_count_in   = 7'(csr_wdata);
            kcs_pkg::REG_INTERP_MODE: interp_mode_in = 2'(csr_wdata);
            kcs_pkg::REG_PLAY_SPEED:  play_speed_in  = csr_wdata;
            kcs_pkg::REG_PLAY_ENABLE: play_enable_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         kcs_pkg::ST_IDLE: begin
            delta_in = req_if.delta_time;
            idx_in   = '0;
            step_in  = kcs_pkg::STEP_SPEED;
         end
         kcs_pkg::ST_SRCH_CMP: begin
            if (rd_time > play_time_ff) begin
               // First key later than the play time; before the first key both
               // ends of the pair are key 0.
               done_in = 1'b0;
               hi_in   = idx_ff[AW-1:0];
               lo_in   = (idx_ff == '0) ? '0 : AW'(idx_ff - 1'b1);
            end else if ((idx_ff + 1'b1) == n_eff) begin
               // At or past the last key: clamp to the final interval.
               done_in = 1'b1;
               if (n_eff > CW'(1)) begin
                  hi_in = AW'(n_eff - 1'b1);
                  lo_in = AW'(n_eff - CW'(2));
               end else begin
                  hi_in = '0;
                  lo_in = '0;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         kcs_pkg::ST_HI_RD: begin
            t_lo_in    = rd_time;
            v0_in      = rd_value;
            out_tan_in = rd_out_tan;
         end
         kcs_pkg::ST_HI_CAP: begin
            t_hi_in   = rd_time;
            v1_in     = rd_value;
            in_tan_in = rd_in_tan;
         end
         kcs_pkg::ST_DIV_INIT: begin
            if (span_ok) begin
               dur_in = t_hi_ff - t_lo_ff;
               f_in   = el_ge_dur ? 17'd65536 : '0;
            end else begin
               dur_in = '0;
               f_in   = '0;
            end
         end
         kcs_pkg::ST_DIV_RUN: begin
            f_in = {1'b0, div_q};
         end
         kcs_pkg::ST_CALC: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               kcs_pkg::STEP_LIN_V0: begin
                  npt_in = (pt_sum[40:32] != '0) ? '1 : pt_sum[31:0];
               end
               kcs_pkg::STEP_LIN_V1: acc_in = kcs_pkg::ACC_W'(prod);
               kcs_pkg::STEP_F2:     acc_in = acc_ff + kcs_pkg::ACC_W'(prod);
               kcs_pkg::STEP_F3:     f2_in  = prod[33:0];
               kcs_pkg::STEP_M0:     f3_in  = prod[48:0];
               kcs_pkg::STEP_M1: begin
                  m0_in  = tan_rnd[47:0];
                  h00_in = x00[49:32];
                  h10_in = x10[49:32];
                  h01_in = x01[49:32];
                  h11_in = x11[49:32];
               end
               kcs_pkg::STEP_H00:    m1_in  = tan_rnd[47:0];
               kcs_pkg::STEP_H01:    acc_in = kcs_pkg::ACC_W'(prod);
               kcs_pkg::STEP_H10_LO: acc_in = acc_ff + kcs_pkg::ACC_W'(prod);
               kcs_pkg::STEP_H10_HI: acc_in = acc_ff + kcs_pkg::ACC_W'(prod);
               kcs_pkg::STEP_H11_LO: acc_in = acc_ff + (kcs_pkg::ACC_W'(prod) <<< 24);
               kcs_pkg::STEP_H11_HI: acc_in = acc_ff + kcs_pkg::ACC_W'(prod);
               kcs_pkg::STEP_LAST:   acc_in = acc_ff + (kcs_pkg::ACC_W'(prod) <<< 24);
               default: ;
            endcase
         end
         kcs_pkg::ST_FINISH: begin
            if (interp_mode_ff == kcs_pkg::INTERP_STEP) begin
               sample_in = v0_ff;
            end else if (rnd > 56'sh7FFF_FFFF) begin
               sample_in = 32'sh7FFF_FFFF;
            end else if (rnd < -56'sh8000_0000) begin
               sample_in = 32'sh8000_0000;
            end else begin
               sample_in = rnd[31:0];
            end
            complete_in  = done_ff;
            lower_in     = 6'(lo_ff);
            play_time_in = done_ff ? '0 : npt_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= kcs_pkg::ST_IDLE;
         key_count_ff   <= 7'd1;
         interp_mode_ff <= kcs_pkg::INTERP_LINEAR;
         play_speed_ff  <= 16'd256;
         play_enable_ff <= 1'b1;
         play_time_ff   <= '0;
         step_ff        <= kcs_pkg::STEP_SPEED;
         idx_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         key_count_ff   <= key_count_in;
         interp_mode_ff <= interp_mode_in;
         play_speed_ff  <= play_speed_in;
         play_enable_ff <= play_enable_in;
         play_time_ff   <= play_time_in;
         step_ff        <= step_in;
         idx_ff         <= idx_in;
      end
      delta_ff    <= delta_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      done_ff     <= done_in;
      t_lo_ff     <= t_lo_in;
      t_hi_ff     <= t_hi_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      out_tan_ff  <= out_tan_in;
      in_tan_ff   <= in_tan_in;
      dur_ff      <= dur_in;
      f_ff        <= f_in;
      acc_ff      <= acc_in;
      f2_ff       <= f2_in;
      f3_ff       <= f3_in;
      m0_ff       <= m0_in;
      m1_ff       <= m1_in;
      h00_ff      <= h00_in;
      h01_ff      <= h01_in;
      h10_ff      <= h10_in;
      h11_ff      <= h11_in;
      npt_ff      <= npt_in;
      sample_ff   <= sample_in;
      complete_ff <= complete_in;
      lower_ff    <= lower_in;
   end

   // The block never takes a request while a result is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request taken while a result is pending");

   // Once a result is taken the block is ready again in the next cycle.
   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready) |=> req_if.ready)
      else $error("block not ready after result handshake");

   // A completed sample returns the play time to zero.
   a_complete_rewinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.sample_complete) |-> (play_time_ff == '0))
      else $error("play time not rewound on completion");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == kcs_pkg::ST_DIV_RUN))
      else $error("divider finished outside its wait state");

   // The factor never exceeds one.
   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kcs_pkg::ST_CALC) |-> (f_ff <= 17'd65536))
      else $error("interpolation factor out of range");

endmodule

// ===== hw/rtl/kcs_ram.sv =====
// Generic single write, single read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module kcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/kcs_mul.sv =====
// Shared signed multiplier of the sampler with a registered product.
// Depends on kcs_pkg.
`timescale 1ns / 1ps

module kcs_mul (
   input  logic                             clock,
   input  logic signed [kcs_pkg::MUL_W-1:0]  op_a,
   input  logic signed [kcs_pkg::MUL_W-1:0]  op_b,
   output logic signed [kcs_pkg::PROD_W-1:0] product
);

   logic signed [kcs_pkg::PROD_W-1:0] prod_ff;
   logic signed [kcs_pkg::PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

// ===== hw/rtl/kcs_div.sv =====
// Restoring divider giving the interpolation factor one quotient bit a cycle.
// Depends on kcs_pkg; the dividend must be below the divisor.
`timescale 1ns / 1ps

module kcs_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [kcs_pkg::WORD_W-1:0]      dividend,
   input  logic [kcs_pkg::WORD_W-1:0]      divisor,
   output logic                            done,
   output logic [kcs_pkg::FRAC_BITS-1:0]   quotient
);

   localparam int CW = $clog2(kcs_pkg::FRAC_BITS + 1);

   logic [kcs_pkg::WORD_W:0]          rem_ff, rem_in;
   logic [kcs_pkg::WORD_W-1:0]        dsr_ff, dsr_in;
   logic [kcs_pkg::FRAC_BITS-1:0]     quo_ff, quo_in;
   logic [CW-1:0]                     cnt_ff, cnt_in;
   logic                              done_ff, done_in;
   logic [kcs_pkg::WORD_W:0]          shifted;

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      shifted = {rem_ff[kcs_pkg::WORD_W-1:0], 1'b0};
      if (start) begin
         rem_in = {1'b0, dividend};
         dsr_in = divisor;
         quo_in = '0;
         cnt_in = CW'(kcs_pkg::FRAC_BITS);
      end else if (cnt_ff != '0) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = shifted - {1'b0, dsr_ff};
            quo_in = {quo_ff[kcs_pkg::FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[kcs_pkg::FRAC_BITS-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== verif/kcs_checker.sv =====
// Scoreboard for the keyframe curve sampler: watches both channels and the CSR port.
// Depends on kcs_pkg, kcs_req_if and kcs_rsp_if.
`timescale 1ns / 1ps

module kcs_checker (
   input  logic  clock,
   input  logic  reset,
   kcs_req_if    req,
   kcs_rsp_if    rsp,
   input  logic                          csr_we,
   input  logic [kcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kcs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int    fail_count,
   output int    outstanding
);

   typedef struct packed {
      logic signed [31:0] value;
      logic               complete;
      logic [5:0]         lower;
   } sample_type;

   logic [31:0] times [kcs_pkg::KEYS];
   logic [31:0] values [kcs_pkg::KEYS];
   logic [31:0] in_tans [kcs_pkg::KEYS];
   logic [31:0] out_tans [kcs_pkg::KEYS];
   logic [31:0] play_time;
   logic [6:0]  cfg_count;
   logic [1:0]  cfg_interp;
   logic [15:0] cfg_speed;
   logic        cfg_enable;

   sample_type expected_samples [$];

   assign outstanding = expected_samples.size();

   // Round half up of x / 2^s; the arithmetic shift floors.
   function automatic logic signed [95:0] round_q(input logic signed [95:0] x, input int s);
      return (x + (96'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic bit advance_curve(input logic [31:0] delta, output sample_type s);
      int unsigned n, hi, lo;
      logic [31:0] dur, el;
      logic [63:0] q, npt;
      logic [16:0] f;
      logic signed [95:0] ff, f2, f3, h00, h10, h01, h11, m0, m1, v0, v1, d, t, res;
      bit done;
      s = '0;
      if (!cfg_enable) return 0;
      n = {25'd0, cfg_count};
      if (n < 1) n = 1;
      if (n > kcs_pkg::KEYS) n = kcs_pkg::KEYS;
      hi = 0;
      while (hi < n && !(times[hi] > play_time)) hi++;
      done = 0;
      if (hi == 0) begin
         lo = 0;
      end else if (hi == n) begin
         if (n > 1) begin
            hi = n - 1;
            lo = hi - 1;
         end else begin
            hi = 0;
            lo = 0;
         end
         done = 1;
      end else begin
         lo = hi - 1;
      end
      f = 0;
      dur = 0;
      if (times[hi] > times[lo]) begin
         dur = times[hi] - times[lo];
         el = (play_time >= times[lo]) ? play_time - times[lo] : 32'd0;
         q = {16'd0, el, 16'd0} / {32'd0, dur};
         f = (q > 64'd65536) ? 17'd65536 : q[16:0];
      end
      v0 = $signed(values[lo]);
      v1 = $signed(values[hi]);
      ff = {79'd0, f};
      d = {64'd0, dur};
      case (cfg_interp)
         kcs_pkg::INTERP_STEP: res = v0;
         kcs_pkg::INTERP_CUBIC: begin
            f2 = ff * ff;
            f3 = f2 * ff;
            h00 = round_q(2 * f3 - 3 * (f2 <<< 16) + (96'sd1 <<< 48), 32);
            h10 = round_q(f3 - 2 * (f2 <<< 16) + (ff <<< 32), 32);
            h01 = round_q(-2 * f3 + 3 * (f2 <<< 16), 32);
            h11 = round_q(f3 - (f2 <<< 16), 32);
            t = $signed(out_tans[lo]);
            m0 = round_q(t * d, 16);
            t = $signed(in_tans[hi]);
            m1 = round_q(t * d, 16);
            res = round_q(h00 * v0 + h10 * m0 + h01 * v1 + h11 * m1, 16);
         end
         default: res = round_q(v0 * (96'sd65536 - ff) + v1 * ff, 16);
      endcase
      if (res > $signed(96'h7FFFFFFF)) s.value = 32'h7FFFFFFF;
      else if (res < -$signed(96'h80000000)) s.value = 32'h80000000;
      else s.value = res[31:0];
      s.complete = done;
      s.lower = lo[5:0];
      if (done) begin
         play_time = 0;
      end else begin
         npt = {32'd0, play_time} + (({32'd0, delta} * {48'd0, cfg_speed}) >> 8);
         play_time = (npt > 64'hFFFFFFFF) ? 32'hFFFFFFFF : npt[31:0];
      end
      return 1;
   endfunction

   always @(posedge clock) begin
      sample_type want, got;
      if (reset) begin
         play_time = 0;
         cfg_count = 7'd1;
         cfg_interp = kcs_pkg::INTERP_LINEAR;
         cfg_speed = 16'd256;
         cfg_enable = 1'b1;
         fail_count = 0;
         expected_samples.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               kcs_pkg::REG_KEY_COUNT:   cfg_count = csr_wdata[6:0];
               kcs_pkg::REG_INTERP_MODE: cfg_interp = csr_wdata[1:0];
               kcs_pkg::REG_PLAY_SPEED:  cfg_speed = csr_wdata;
               kcs_pkg::REG_PLAY_ENABLE: cfg_enable = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.sample_value, rsp.sample_complete, rsp.lower_key};
            if (expected_samples.size() == 0) begin
               $error("unexpected sample: value %h complete %0d lower_key %0d",
                      got.value, got.complete, got.lower);
               fail_count++;
            end else begin
               want = expected_samples.pop_front();
               if (got.value !== want.value) begin
                  $error("sample_value: expected %h, actual %h", want.value, got.value);
                  fail_count++;
               end
               if (got.complete !== want.complete) begin
                  $error("sample_complete: expected %0d, actual %0d",
                         want.complete, got.complete);
                  fail_count++;
               end
               if (got.lower !== want.lower) begin
                  $error("lower_key: expected %0d, actual %0d", want.lower, got.lower);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            if (req.mode == kcs_pkg::MODE_LOAD) begin
               times[req.key_index] = req.key_time;
               in_tans[req.key_index] = req.key_in_tangent;
               values[req.key_index] = req.key_value;
               out_tans[req.key_index] = req.key_out_tangent;
            end else if (advance_curve(req.delta_time, want)) begin
               expected_samples.push_back(want);
            end
         end
      end
   end
endmodule

// ===== verif/tb.sv =====
// Top of the keyframe curve sampler testbench: clock, reset, stimulus and verdict.
// Depends on kcs_pkg, both channel interfaces, the core and kcs_checker.
`timescale 1ns / 1ps

module tb;

   // The fourth interpolation code has no name in the package; it behaves as linear.
   localparam logic [1:0] INTERP_SPARE = 2'd3;
   localparam int HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [kcs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [kcs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   kcs_req_if req_ch ();
   kcs_rsp_if rsp_ch ();

   int fail_count;
   int outstanding;
   int sent = 0;
   bit quiet = 0;          // when set, neither side inserts idle cycles
   bit hold_results = 0;   // asks the receiver for one long hold-off
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;

   always #10 clock = ~clock;

   keyframe_curve_sampler_core DUT (
      .clock(clock), .reset(reset), .req_if(req_ch), .rsp_if(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   kcs_checker checker_i (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   // The handshakes are registered at the rising edge, so the processes that
   // drive at the falling edge see them without any race.
   always @(posedge clock) begin
      req_took <= req_ch.valid && req_ch.ready;
      rsp_took <= rsp_ch.valid && rsp_ch.ready;
   end

   // The receiver draws a stall before every sample it takes. When asked, it
   // holds off for a long stretch so that the block backs up into the request
   // channel.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_results) begin
            hold_results = 0;
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = quiet ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(negedge clock); while (!rsp_took);
      end
   end

   // Offers one request after a random gap (none when quiet) and returns at the
   // falling edge after it has been taken. Valid stays high so that a following
   // request without a gap follows straight on.
   task automatic send_request(input logic mode, input logic [5:0] index,
                               input logic [31:0] key_time, input logic [31:0] in_tan,
                               input logic [31:0] value, input logic [31:0] out_tan,
                               input logic [31:0] delta);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.mode = mode;
      req_ch.key_index = index;
      req_ch.key_time = key_time;
      req_ch.key_in_tangent = in_tan;
      req_ch.key_value = value;
      req_ch.key_out_tangent = out_tan;
      req_ch.delta_time = delta;
      req_ch.valid = 1'b1;
      do @(negedge clock); while (!req_took);
      sent++;
   endtask

   task automatic load_key(input logic [5:0] index, input logic [31:0] key_time,
                           input logic [31:0] in_tan, input logic [31:0] value,
                           input logic [31:0] out_tan);
      send_request(kcs_pkg::MODE_LOAD, index, key_time, in_tan, value, out_tan, $urandom);
   endtask

   task automatic advance(input logic [31:0] delta);
      send_request(kcs_pkg::MODE_ADVANCE, 6'($urandom), $urandom, $urandom, $urandom,
                   $urandom, delta);
   endtask

   // Waits until every expected sample has arrived and then lets the block
   // finish whatever load or paused request it may still be working on.
   task automatic settle;
      req_ch.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [kcs_pkg::CSR_IDX_W-1:0] index,
                            input logic [kcs_pkg::CSR_DATA_W-1:0] data);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(input logic [6:0] count, input logic [1:0] interp,
                            input logic [15:0] speed, input logic enable);
      csr_write(kcs_pkg::REG_KEY_COUNT, {9'd0, count});
      csr_write(kcs_pkg::REG_INTERP_MODE, {14'd0, interp});
      csr_write(kcs_pkg::REG_PLAY_SPEED, speed);
      csr_write(kcs_pkg::REG_PLAY_ENABLE, {15'd0, enable});
   endtask

   function automatic logic [31:0] pick_delta;
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 32'd0;
      if (r == 1) return $urandom;
      if (r == 2) return 32'hFFFFFFFF;
      return $urandom_range(0, 32'h30000);
   endfunction

   function automatic logic [31:0] pick_word;
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h7FFFFFFF;
      if (r == 1) return 32'h80000000;
      if (r < 5) return $urandom_range(0, 32'h60000) - 32'h30000;
      return $urandom;
   endfunction

   initial begin
      int phase, keys, advances, r;
      logic [6:0] count;
      logic [1:0] interp;
      logic [15:0] speed;
      logic enable;
      logic [31:0] t;
      bit scrambled;

      req_ch.valid = 1'b0;
      req_ch.mode = kcs_pkg::MODE_LOAD;
      req_ch.key_index = '0;
      req_ch.key_time = '0;
      req_ch.key_in_tangent = '0;
      req_ch.key_value = '0;
      req_ch.key_out_tangent = '0;
      req_ch.delta_time = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. With one key the play time starts before it, reaches it
      // and then completes, which wraps the play time back to zero.
      configure(7'd1, kcs_pkg::INTERP_LINEAR, 16'd256, 1'b1);
      load_key(6'd0, 32'h10000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
      advance(32'h8000);
      advance(32'h8000);
      advance(32'h0);
      advance(32'h0);
      load_key(6'd1, 32'h30000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
      load_key(6'd63, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      settle();
      // Extreme values and tangents across one interval in the cubic mode.
      configure(7'd2, kcs_pkg::INTERP_CUBIC, 16'd256, 1'b1);
      repeat (5) advance(32'h8000);
      settle();
      // Fastest speed with the largest delta saturates the play time.
      configure(7'd2, kcs_pkg::INTERP_STEP, 16'hFFFF, 1'b1);
      advance(32'hFFFFFFFF);
      advance(32'hFFFFFFFF);
      advance(32'h1);
      settle();
      // Paused: the advance gives no sample and leaves the play time alone.
      configure(7'd2, kcs_pkg::INTERP_LINEAR, 16'd0, 1'b0);
      advance(32'h12345);
      settle();
      // A key count of zero acts as one; the spare mode acts as linear.
      configure(7'd0, INTERP_SPARE, 16'd256, 1'b1);
      advance(32'h4000);
      advance(32'h4000);
      settle();

      // Random phases: each loads its keys in time order, then advances through
      // them with occasional reloads. A few phases scramble the key times.
      phase = 0;
      while (sent < 1000) begin
         r = $urandom_range(0, 9);
         if (r == 0) count = 7'd64;
         else if (r == 1) count = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
         else if (r < 4) count = 7'($urandom_range(1, 64));
         else count = 7'($urandom_range(1, 8));
         keys = (count == 0) ? 1 : (count > 64) ? 64 : int'(count);
         interp = 2'($urandom_range(0, 3));
         r = $urandom_range(0, 7);
         speed = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r < 4) ? 16'd256
                 : 16'($urandom_range(0, 1024));
         enable = ($urandom_range(0, 7) != 0);
         quiet = ($urandom_range(0, 4) == 0);
         scrambled = ($urandom_range(0, 7) == 0);
         configure(count, interp, speed, enable);
         t = $urandom_range(0, 32'h8000);
         for (int k = 0; k < keys; k++) begin
            r = $urandom_range(0, 7);
            t = t + ((r == 0) ? 32'd0 : $urandom_range(1, 32'h40000));
            load_key(k[5:0], scrambled ? $urandom : t, pick_word(), pick_word(),
                     pick_word());
         end
         advances = $urandom_range(10, 40);
         for (int a = 0; a < advances; a++) begin
            if (phase == 3 && a == 2) hold_results = 1;
            if ($urandom_range(0, 9) == 0)
               load_key(6'($urandom_range(0, 63)), $urandom, pick_word(), pick_word(),
                        pick_word());
            else
               advance(pick_delta());
         end
         settle();
         phase++;
      end

      quiet = 0;
      settle();
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
